/* rtl/escape_sequence_decoder_defines.svh */
// assertion macros for the escape sequence decoder checker
// used by esd_checker.sv; needs clk and arst_n in the including scope
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// same-cycle implication, off during reset
`define ESD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define ESD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/esd_pkg.sv */
// shared types, character codes and decode functions of the escape decoder
// no dependencies; imported by esd_front, esd_queue, esd_back and escape_sequence_decoder
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_O         = 8'h6F;
	localparam logic [7:0] CH_D         = 8'h64;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_U         = 8'h75;

	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_NUL = 8'h00;
	localparam logic [7:0] BYTE_TAB = 8'h09;

	localparam logic [4:0] DIGIT_NONE = 5'd31;

	// one queued job: optional escape replay (backslash, letter, digits), then optional byte
	typedef struct packed {
		logic            flush;
		logic [7:0]      letter;
		logic [7:0][7:0] digits;
		logic [3:0]      ndig;
		logic            tail_en;
		logic [7:0]      tail;
	} cmd_t;

	function automatic logic [3:0] esc_size(input logic [7:0] letter);
		case (letter)
			CH_B:    return 4'd8;
			CH_O:    return 4'd3;
			CH_D:    return 4'd3;
			CH_X:    return 4'd2;
			CH_U:    return 4'd4;
			default: return 4'd0;
		endcase
	endfunction

	function automatic logic [4:0] esc_base(input logic [7:0] letter);
		case (letter)
			CH_B:    return 5'd2;
			CH_O:    return 5'd8;
			CH_D:    return 5'd10;
			CH_X:    return 5'd16;
			CH_U:    return 5'd16;
			default: return 5'd0;
		endcase
	endfunction

	// digit value, DIGIT_NONE for anything outside 0-9, a-f, A-F
	function automatic logic [4:0] digit_val(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
		if (c >= 8'h61 && c <= 8'h66) return 5'(c[3:0]) + 5'd9;
		if (c >= 8'h41 && c <= 8'h46) return 5'(c[3:0]) + 5'd9;
		return DIGIT_NONE;
	endfunction

endpackage

`default_nettype wire

/* rtl/esd_front.sv */
// front end: accepts string bytes, tracks escape parsing state, issues jobs
// depends on esd_pkg (cmd_t, character codes, decode functions)
`timescale 1ns / 1ps
`default_nettype none

module esd_front import esd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	input  logic       q_ready,
	output logic       push,
	output cmd_t       push_cmd
);

	typedef enum logic [2:0] {
		MODE_PLAIN  = 3'b001,
		MODE_ESC    = 3'b010,
		MODE_DIGITS = 3'b100
	} mode_t;

	mode_t           mode_q, mode_d;
	logic [7:0]      letter_q, letter_d;
	logic [3:0]      count_q, count_d;
	logic [7:0]      acc_q, acc_d;
	logic [7:0]      digits_q [8];
	logic            digit_we;
	logic            accept;
	logic            has_res;
	logic            starts_esc;
	logic [3:0]      size;
	logic [4:0]      base;
	logic [4:0]      dval;
	logic            dig_ok;
	logic [7:0]      scaled;
	logic [7:0]      acc_new;
	logic [3:0]      count_inc;
	logic [7:0][7:0] digits_pk;
	cmd_t            cmd;

	assign in_ready   = q_ready;
	assign accept     = in_valid && q_ready;
	assign size       = esc_size(letter_q);
	assign base       = esc_base(letter_q);
	assign dval       = digit_val(in_byte);
	assign dig_ok     = dval < base;
	assign count_inc  = count_q + 4'd1;
	assign starts_esc = (in_byte == CH_BACKSLASH) && !end_of_string;

	// a valid digit of an open numeric escape goes into the digit store
	assign digit_we   = (mode_q == MODE_DIGITS) && (size != 4'd0) && dig_ok;

	// value times base, base is one of 2, 8, 10, 16
	always_comb begin
		case (base)
			5'd2:    scaled = {acc_q[6:0], 1'b0};
			5'd8:    scaled = {acc_q[4:0], 3'b000};
			5'd10:   scaled = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0};
			5'd16:   scaled = {acc_q[3:0], 4'b0000};
			default: scaled = acc_q;
		endcase
	end
	assign acc_new = scaled + {4'b0000, dval[3:0]};

	// stored digits with the current one folded in
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			digits_pk[k] = (digit_we && count_q[2:0] == 3'(k)) ? in_byte : digits_q[k];
		end
	end

	always_comb begin
		mode_d   = mode_q;
		letter_d = letter_q;
		count_d  = count_q;
		acc_d    = acc_q;
		has_res  = 1'b0;
		cmd      = '0;
		case (mode_q)
			MODE_ESC: begin
				mode_d      = MODE_PLAIN;
				has_res     = 1'b1;
				cmd.tail_en = 1'b1;
				case (in_byte)
					CH_R:         cmd.tail = BYTE_CR;
					CH_N:         cmd.tail = BYTE_LF;
					CH_ZERO:      cmd.tail = BYTE_NUL;
					CH_T:         cmd.tail = BYTE_TAB;
					CH_BACKSLASH: cmd.tail = CH_BACKSLASH;
					default: begin
						cmd.tail_en = 1'b0;
						if (esc_size(in_byte) == 4'd0 || end_of_string) begin
							cmd.flush  = 1'b1;
							cmd.letter = in_byte;
						end else begin
							has_res  = 1'b0;
							letter_d = in_byte;
							count_d  = 4'd0;
							acc_d    = 8'd0;
							mode_d   = MODE_DIGITS;
						end
					end
				endcase
			end
			MODE_DIGITS: begin
				mode_d = MODE_PLAIN;
				if (size == 4'd0) begin
					if (starts_esc) begin
						mode_d = MODE_ESC;
					end else begin
						has_res     = 1'b1;
						cmd.tail_en = 1'b1;
						cmd.tail    = in_byte;
					end
				end else if (dig_ok) begin
					count_d  = count_inc;
					acc_d    = acc_new;
					if (count_inc >= size) begin
						has_res     = 1'b1;
						cmd.tail_en = 1'b1;
						cmd.tail    = acc_new;
					end else if (end_of_string) begin
						has_res    = 1'b1;
						cmd.flush  = 1'b1;
						cmd.letter = letter_q;
						cmd.ndig   = count_inc;
					end else begin
						mode_d = MODE_DIGITS;
					end
				end else begin
					// bad digit: replay the escape, then treat the byte as plain text
					has_res    = 1'b1;
					cmd.flush  = 1'b1;
					cmd.letter = letter_q;
					cmd.ndig   = count_q;
					if (starts_esc) begin
						mode_d = MODE_ESC;
					end else begin
						cmd.tail_en = 1'b1;
						cmd.tail    = in_byte;
					end
				end
			end
			default: begin
				mode_d = MODE_PLAIN;
				if (starts_esc) begin
					mode_d = MODE_ESC;
				end else begin
					has_res     = 1'b1;
					cmd.tail_en = 1'b1;
					cmd.tail    = in_byte;
				end
			end
		endcase
		cmd.digits = digits_pk;
	end

	assign push     = accept && has_res;
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			letter_q <= 8'd0;
			count_q  <= 4'd0;
			acc_q    <= 8'd0;
		end else if (accept) begin
			mode_q   <= mode_d;
			letter_q <= letter_d;
			count_q  <= count_d;
			acc_q    <= acc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && digit_we) begin
			digits_q[count_q[2:0]] <= in_byte;
		end
	end

endmodule

`default_nettype wire

/* rtl/esd_queue.sv */
// two-entry job queue between the front end and the back end
// depends on esd_pkg (cmd_t)
`timescale 1ns / 1ps
`default_nettype none

module esd_queue import esd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic q_ready,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign q_ready    = cnt_q != 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head_cmd   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

/* rtl/esd_back.sv */
// back end: walks the head job one output beat at a time into the output register
// depends on esd_pkg (cmd_t, CH_BACKSLASH)
`timescale 1ns / 1ps
`default_nettype none

module esd_back import esd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic [3:0] pos_q;
	logic [3:0] eff;
	logic [3:0] last_pos;
	logic [2:0] dig_idx;
	logic       is_last;
	logic       load;
	logic [7:0] beat;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;

	// jobs without a replay start straight at the tail slot
	assign eff      = pos_q + (head_cmd.flush ? 4'd0 : 4'd2);
	assign last_pos = 4'd1 + head_cmd.ndig + {3'b000, head_cmd.tail_en};
	assign is_last  = eff == last_pos;
	assign dig_idx  = 3'(eff - 4'd2);

	always_comb begin
		if (eff == 4'd0) begin
			beat = CH_BACKSLASH;
		end else if (eff == 4'd1) begin
			beat = head_cmd.letter;
		end else if (eff < 4'd2 + head_cmd.ndig) begin
			beat = head_cmd.digits[dig_idx];
		end else begin
			beat = head_cmd.tail;
		end
	end

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= 4'd0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			pos_q       <= is_last ? 4'd0 : pos_q + 4'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= beat;
			run_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

endmodule

`default_nettype wire

/* rtl/escape_sequence_decoder.sv */
// top level of the backslash escape decoder: front end, job queue, back end
// depends on esd_pkg, esd_front, esd_queue, esd_back
`timescale 1ns / 1ps
`default_nettype none

// Decodes a backslash-escaped string arriving one byte per input beat, with
// end_of_string marking the last byte. \r \n \0 \t and \\ give CR, LF, NUL, TAB
// and a backslash; \b, \o, \d, \x and \u read 8 binary, 3 octal, 3 decimal,
// 2 hex or 4 hex digits and give their value modulo 256 as one byte. An
// unknown letter, a bad digit or a string that ends inside an escape makes the
// block replay the backslash, the letter and the digits seen so far as text,
// after which a bad digit byte is handled as ordinary text (it may open a new
// escape). Each input beat produces zero to ten output beats; run_last marks
// the last beat caused by an input. Timing: the front end classifies one input
// beat per cycle and hands any work to a two-entry queue; the back end drives
// one output beat per cycle unless out_ready holds it, so an input whose work
// is n beats occupies the back end for n output beats, and the input side
// stalls only once the queue is full. First output passes through the queue
// slot and then the output register. Ordinary text runs at one byte per cycle
// while the output is not stalled; each replayed byte is one back-end beat.
module escape_sequence_decoder import esd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	// jobs from the front end into the queue
	logic push;
	cmd_t push_cmd;
	logic q_ready;

	// head of the queue toward the back end
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	// front end holds the parse mode, escape letter, digit count, running
	// value and the digits read so far
	esd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.q_ready       (q_ready),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// decouples classification from output so each side stalls on its own
	esd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_ready    (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// back end expands each job into output beats through a registered output
	esd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last)
	);

endmodule

`default_nettype wire

/* rtl/esd_checker.sv */
// port-level checks of the escape decoder, attached to the top level by bind
// depends on escape_sequence_decoder_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "escape_sequence_decoder_defines.svh"

module esd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       end_of_string,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last
);

	// a stalled input beat holds
	`ESD_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
		in_valid && $stable(in_byte) && $stable(end_of_string),
		"input beat changed while stalled")

	// a stalled output beat holds
	`ESD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(run_last),
		"output beat changed while stalled")

	// a run that is not finished keeps the output busy
	`ESD_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_last, out_valid,
		"output run broke off before its last beat")

	// input stalls only when the back end has a beat on offer
	`ESD_ASSERT_NOW(a_stall_has_work, !in_ready, out_valid,
		"input stalled with no output pending")

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);

`default_nettype wire
